>>> sv/sdhs_pkg.sv
// Shared constants, widths and interface structs of the squared-distance heap sorter.
package sdhs_pkg;

    localparam int CAPACITY   = 64;
    localparam int COORD_BITS = 16;
    localparam int KEY_W      = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = ADDR_W + 2;
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int SUM_W      = SQ_W + 1;
    localparam int EXT_W      = (SUM_W > KEY_W) ? SUM_W : KEY_W + 1;

    // request from the sequencer to the heap engine
    typedef struct packed {
        logic             ins;
        logic             pop;
        logic [KEY_W-1:0] key;
    } t_heap_cmd;

    // heap engine status back to the sequencer
    typedef struct packed {
        logic             done;
        logic             pop_valid;
        logic             pop_last;
        logic [KEY_W-1:0] pop_key;
        logic [CNT_W-1:0] count;
    } t_heap_stat;

endpackage

>>> sv/sdhs_key.sv
// Squared-distance key unit: one shared multiplier squares x then y, then a saturating add.
module sdhs_key (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [sdhs_pkg::COORD_BITS-1:0] i_x,
    input  logic signed [sdhs_pkg::COORD_BITS-1:0] i_y,
    output logic                                 o_done,
    output logic [sdhs_pkg::KEY_W-1:0]           o_key
);

    typedef enum logic [4:0] {
        K_IDLE = 5'b00001,
        K_SQX  = 5'b00010,
        K_SQY  = 5'b00100,
        K_SUM  = 5'b01000,
        K_DONE = 5'b10000
    } t_key_state;

    t_key_state r_state, n_state;

    logic [sdhs_pkg::COORD_BITS-1:0] r_mx, r_my;
    logic [sdhs_pkg::SQ_W-1:0]       r_prod, r_acc;
    logic [sdhs_pkg::KEY_W-1:0]      r_key;
    logic [sdhs_pkg::COORD_BITS-1:0] mul_op;
    logic [sdhs_pkg::COORD_BITS-1:0] abs_x, abs_y;
    logic [sdhs_pkg::SUM_W-1:0]      sum;
    logic [sdhs_pkg::EXT_W-1:0]      sum_ext;
    logic [sdhs_pkg::KEY_W-1:0]      sat_key;

    // magnitude in COORD_BITS unsigned bits; the most negative value maps to 2^(n-1)
    assign abs_x = i_x[sdhs_pkg::COORD_BITS-1] ? (sdhs_pkg::COORD_BITS'(0) - i_x) : i_x;
    assign abs_y = i_y[sdhs_pkg::COORD_BITS-1] ? (sdhs_pkg::COORD_BITS'(0) - i_y) : i_y;

    assign mul_op  = (r_state == K_SQX) ? r_mx : r_my;
    assign sum     = sdhs_pkg::SUM_W'(r_acc) + sdhs_pkg::SUM_W'(r_prod);
    assign sum_ext = sdhs_pkg::EXT_W'(sum);
    assign sat_key = (|sum_ext[sdhs_pkg::EXT_W-1:sdhs_pkg::KEY_W]) ?
                     {sdhs_pkg::KEY_W{1'b1}} : sum_ext[sdhs_pkg::KEY_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            K_IDLE: if (i_start) n_state = K_SQX;
            K_SQX:  n_state = K_SQY;
            K_SQY:  n_state = K_SUM;
            K_SUM:  n_state = K_DONE;
            K_DONE: n_state = K_IDLE;
            default: n_state = K_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= K_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == K_IDLE && i_start) begin
            r_mx <= abs_x;
            r_my <= abs_y;
        end
        if (r_state == K_SQX || r_state == K_SQY) begin
            r_prod <= sdhs_pkg::SQ_W'(mul_op * mul_op);
        end
        if (r_state == K_SQY) begin
            r_acc <= r_prod;
        end
        if (r_state == K_SUM) begin
            r_key <= sat_key;
        end
    end

    assign o_done = (r_state == K_DONE);
    assign o_key  = r_key;

endmodule

>>> sv/sdhs_heap.sv
// Binary min-heap engine: key memory with hole-based sift-up and sift-down sequencing.
module sdhs_heap (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sdhs_pkg::t_heap_cmd  i_cmd,
    output sdhs_pkg::t_heap_stat o_stat
);

    typedef enum logic [5:0] {
        H_IDLE   = 6'b000001,
        H_UP_RD  = 6'b000010,
        H_UP_CMP = 6'b000100,
        H_DN_TOP = 6'b001000,
        H_DN_RD  = 6'b010000,
        H_DN_CMP = 6'b100000
    } t_heap_state;

    t_heap_state r_state, n_state;

    logic [sdhs_pkg::KEY_W-1:0]  mem [sdhs_pkg::CAPACITY];
    logic [sdhs_pkg::KEY_W-1:0]  r_rd0, r_rd1;
    logic [sdhs_pkg::CNT_W-1:0]  r_count, n_count;
    logic [sdhs_pkg::ADDR_W-1:0] r_pos, n_pos;
    logic [sdhs_pkg::KEY_W-1:0]  r_key, n_key;

    logic                        wr_en, rd_en, done, pop_valid;
    logic [sdhs_pkg::ADDR_W-1:0] wr_addr, rd_addr0, rd_addr1;
    logic [sdhs_pkg::KEY_W-1:0]  wr_data;

    logic [sdhs_pkg::ADDR_W-1:0] parent;
    logic [sdhs_pkg::IDX_W-1:0]  child_x, right_x, cnt_x;
    logic                        pick_right;
    logic [sdhs_pkg::KEY_W-1:0]  min_key;
    logic [sdhs_pkg::ADDR_W-1:0] min_addr;

    assign parent     = (r_pos - sdhs_pkg::ADDR_W'(1)) >> 1;
    assign child_x    = sdhs_pkg::IDX_W'({r_pos, 1'b1});
    assign right_x    = child_x + sdhs_pkg::IDX_W'(1);
    assign cnt_x      = sdhs_pkg::IDX_W'(r_count);
    assign pick_right = (right_x < cnt_x) && (r_rd1 < r_rd0);
    assign min_key    = pick_right ? r_rd1 : r_rd0;
    assign min_addr   = pick_right ? right_x[sdhs_pkg::ADDR_W-1:0]
                                   : child_x[sdhs_pkg::ADDR_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_key     = r_key;
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_data   = r_key;
        rd_en     = 1'b0;
        rd_addr0  = '0;
        rd_addr1  = '0;
        done      = 1'b0;
        pop_valid = 1'b0;
        unique case (r_state)
            H_IDLE: begin
                if (i_cmd.ins) begin
                    // open a hole at the end, carry the new key upward
                    n_key   = i_cmd.key;
                    n_pos   = sdhs_pkg::ADDR_W'(r_count);
                    n_count = r_count + sdhs_pkg::CNT_W'(1);
                    n_state = H_UP_RD;
                end else if (i_cmd.pop) begin
                    rd_en    = 1'b1;
                    rd_addr0 = '0;
                    rd_addr1 = sdhs_pkg::ADDR_W'(r_count - sdhs_pkg::CNT_W'(1));
                    n_count  = r_count - sdhs_pkg::CNT_W'(1);
                    n_state  = H_DN_TOP;
                end
            end
            H_UP_RD: begin
                if (r_pos == '0) begin
                    wr_en   = 1'b1;
                    done    = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr0 = parent;
                    n_state  = H_UP_CMP;
                end
            end
            H_UP_CMP: begin
                wr_en = 1'b1;
                if (r_key >= r_rd0) begin
                    done    = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    // move the parent down into the hole
                    wr_data = r_rd0;
                    n_pos   = parent;
                    n_state = H_UP_RD;
                end
            end
            H_DN_TOP: begin
                pop_valid = 1'b1;
                n_key     = r_rd1;
                n_pos     = '0;
                if (r_count == '0) begin
                    done    = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    n_state = H_DN_RD;
                end
            end
            H_DN_RD: begin
                if (child_x >= cnt_x) begin
                    wr_en   = 1'b1;
                    done    = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr0 = child_x[sdhs_pkg::ADDR_W-1:0];
                    rd_addr1 = right_x[sdhs_pkg::ADDR_W-1:0];
                    n_state  = H_DN_CMP;
                end
            end
            H_DN_CMP: begin
                wr_en = 1'b1;
                if (r_key <= min_key) begin
                    done    = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    // lift the smaller child into the hole
                    wr_data = min_key;
                    n_pos   = min_addr;
                    n_state = H_DN_RD;
                end
            end
            default: n_state = H_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_key <= n_key;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd0 <= mem[rd_addr0];
            r_rd1 <= mem[rd_addr1];
        end
    end

    always_comb begin
        o_stat.done      = done;
        o_stat.pop_valid = pop_valid;
        o_stat.pop_last  = (r_count == '0);
        o_stat.pop_key   = r_rd0;
        o_stat.count     = r_count;
    end

endmodule

>>> sv/squared_distance_heap_sort_core.sv
// Top level of the squared-distance heap sorter: request sequencer, drop flag and result port.
//
// Each request carries one signed point. The block keys it by x*x + y*y
// (saturating at 32 bits) and inserts the key into a binary min-heap of
// CAPACITY entries. A request with i_final_point high is stored or dropped, and
// then the whole heap drains: one result per stored key in ascending order,
// duplicates kept, o_run_last high on the final key, o_overflowed high on
// every key of a set in which some point found the heap full and was
// dropped. The heap and the drop flag then start empty for the next set.
// The receiver cannot stall: each result sits on the o_ ports for exactly
// one cycle with o_valid high and must be captured then. busy is high from
// the accepting edge until the block can take the next request.
// After the accepting edge busy stays high while the key forms
// (one shared multiplier, squaring x then y, then the add), then through
// the sift-up of a key that lands L levels below the root, a registered
// memory read and a compare per level; a dropped point skips the sift-up.
// The next request is taken while busy is low. Each drained key passes
// through a sift-down, L at most log2(CAPACITY). The heap memory needs no
// clearing pass after reset.
module squared_distance_heap_sort_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [sdhs_pkg::COORD_BITS-1:0] i_x_coord,
    input  logic signed [sdhs_pkg::COORD_BITS-1:0] i_y_coord,
    input  logic                                   i_final_point,
    output logic                                   o_valid,
    output logic [sdhs_pkg::KEY_W-1:0]             o_squared_distance,
    output logic                                   o_run_last,
    output logic                                   o_overflowed
);

    typedef enum logic [4:0] {
        T_IDLE = 5'b00001,
        T_KEY  = 5'b00010,
        T_INS  = 5'b00100,
        T_POP  = 5'b01000,
        T_WAIT = 5'b10000
    } t_top_state;

    t_top_state r_state, n_state;

    logic r_final, n_final;
    logic r_drop, n_drop;
    logic r_out_valid;
    logic [sdhs_pkg::KEY_W-1:0] r_out_dist;
    logic r_out_last, r_out_ovf;

    logic                       key_start, key_done;
    logic [sdhs_pkg::KEY_W-1:0] key;
    sdhs_pkg::t_heap_cmd        heap_cmd;
    sdhs_pkg::t_heap_stat       heap_stat;

    assign key_start = start && (r_state == T_IDLE);

    sdhs_key u_key (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (key_start),
        .i_x     (i_x_coord),
        .i_y     (i_y_coord),
        .o_done  (key_done),
        .o_key   (key)
    );

    sdhs_heap u_heap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (heap_cmd),
        .o_stat  (heap_stat)
    );

    always_comb begin
        n_state      = r_state;
        n_final      = r_final;
        n_drop       = r_drop;
        heap_cmd.ins = 1'b0;
        heap_cmd.pop = 1'b0;
        heap_cmd.key = key;
        unique case (r_state)
            T_IDLE: begin
                if (start) begin
                    n_final = i_final_point;
                    n_state = T_KEY;
                end
            end
            T_KEY: begin
                if (key_done) begin
                    if (heap_stat.count < sdhs_pkg::CNT_W'(sdhs_pkg::CAPACITY)) begin
                        heap_cmd.ins = 1'b1;
                        n_state      = T_INS;
                    end else begin
                        // heap full: drop the point, flag the set
                        n_drop  = 1'b1;
                        n_state = r_final ? T_POP : T_IDLE;
                    end
                end
            end
            T_INS: begin
                if (heap_stat.done) begin
                    n_state = r_final ? T_POP : T_IDLE;
                end
            end
            T_POP: begin
                heap_cmd.pop = 1'b1;
                n_state      = T_WAIT;
            end
            T_WAIT: begin
                if (heap_stat.done) begin
                    if (heap_stat.count == '0) begin
                        // run complete: start the next set clean
                        n_drop  = 1'b0;
                        n_state = T_IDLE;
                    end else begin
                        n_state = T_POP;
                    end
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_drop      <= n_drop;
            r_out_valid <= heap_stat.pop_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_final <= n_final;
        if (heap_stat.pop_valid) begin
            r_out_dist <= heap_stat.pop_key;
            r_out_last <= heap_stat.pop_last;
            r_out_ovf  <= r_drop;
        end
    end

    assign busy               = (r_state != T_IDLE);
    assign o_valid            = r_out_valid;
    assign o_squared_distance = r_out_dist;
    assign o_run_last         = r_out_last;
    assign o_overflowed       = r_out_ovf;

endmodule

>>> test/tb_squared_distance_heap_sort_core.sv
// Self-checking testbench for the squared-distance heap sorter core.
//
// Points are queued by the stimulus block and fed to the core one request at
// a time through the start/busy handshake. The checker watches the same
// handshake: every accepted point is keyed by x*x + y*y and kept in an
// ascending list for the current set. Points beyond CAPACITY are dropped and
// mark the set as overflowed. On the final point of a set the whole list
// becomes the expected sorted run. The last key carries run_last and every
// key carries the overflow mark. Each o_valid strobe is compared field by
// field with the oldest key still due.
module tb_squared_distance_heap_sort_core;

    localparam int CB         = sdhs_pkg::COORD_BITS;
    localparam int KW         = sdhs_pkg::KEY_W;
    localparam int CAP        = sdhs_pkg::CAPACITY;
    localparam int RAND_ITEMS = 450;
    // no idling over the last stretch of requests
    localparam int QUIET_TAIL = 60;
    // settling time after the last expected key, well beyond one key's sift-down
    localparam int DRAIN_WAIT = 200;

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 fin;
    } t_point;

    typedef struct {
        logic [KW-1:0] sq_dist;
        logic          last;
        logic          ovf;
    } t_sorted_key;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 start         = 1'b0;
    logic signed [CB-1:0] i_x_coord     = '0;
    logic signed [CB-1:0] i_y_coord     = '0;
    logic                 i_final_point = 1'b0;
    logic                 busy;
    logic                 o_valid;
    logic [KW-1:0]        o_squared_distance;
    logic                 o_run_last;
    logic                 o_overflowed;

    t_point        point_queue[$];   // requests not yet driven
    t_sorted_key   keys_due[$];      // sorted results still to arrive
    logic [KW-1:0] set_keys[$];      // keys of the open set, ascending
    logic          set_dropped = 1'b0;
    int            gap_left    = 0;
    int            fail_count  = 0;

    squared_distance_heap_sort_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_x_coord          (i_x_coord),
        .i_y_coord          (i_y_coord),
        .i_final_point      (i_final_point),
        .o_valid            (o_valid),
        .o_squared_distance (o_squared_distance),
        .o_run_last         (o_run_last),
        .o_overflowed       (o_overflowed)
    );

    always #5 i_clk = ~i_clk;

    // Key of a point: magnitude of each coordinate squared, summed, saturated to KW bits.
    function automatic logic [KW-1:0] squared_key(logic signed [CB-1:0] x,
                                                  logic signed [CB-1:0] y);
        longint unsigned mx;
        longint unsigned my;
        longint unsigned sum;
        mx = longint'(x);
        my = longint'(y);
        if (x < 0) mx = -mx;
        if (y < 0) my = -my;
        sum = mx * mx + my * my;
        if (sum > 64'hFFFF_FFFF) return '1;
        return sum[KW-1:0];
    endfunction

    // Mix full-range values with extremes and a narrow band that yields duplicate keys.
    function automatic logic signed [CB-1:0] pick_coord();
        logic signed [CB-1:0] v;
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = {1'b1, {(CB-1){1'b0}}};
                    1: v = {1'b0, {(CB-1){1'b1}}};
                    2: v = '1;
                    3: v = '0;
                    default: v = CB'(1);
                endcase
            end
            1, 2: v = CB'($urandom_range(0, 16) - 8);
            default: v = CB'($urandom);
        endcase
        return v;
    endfunction

    task automatic push_point(int x, int y, logic fin);
        t_point p;
        p.x = CB'(x);
        p.y = CB'(y);
        p.fin = fin;
        point_queue.insert(point_queue.size(), p);
    endtask

    // Queue a set of n random points, the last one marked final.
    task automatic push_random_set(int n);
        for (int i = 0; i < n; i++)
            push_point(int'(pick_coord()), int'(pick_coord()), i == n - 1);
    endtask

    // Driver: present the next queued point and hold it until the core takes it.
    // Idle gaps count down only while the core is ready, so they delay the
    // next request by a real amount rather than hiding under busy.
    always @(posedge i_clk) begin : drive_requests
        t_point pt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (gap_left > 0) begin
                start <= 1'b0;
                if (!busy) gap_left <= gap_left - 1;
            end else if (point_queue.size() > 0) begin
                pt = point_queue.pop_front();
                i_x_coord     <= pt.x;
                i_y_coord     <= pt.y;
                i_final_point <= pt.fin;
                start         <= 1'b1;
                if (point_queue.size() >= QUIET_TAIL && $urandom_range(0, 2) == 0)
                    gap_left <= $urandom_range(1, 11);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check any strobed result first, then predict from an accepted request.
    always @(posedge i_clk) begin : check_results
        t_sorted_key  want;
        logic [KW-1:0] key;
        int            pos;
        if (i_rst_n) begin
            if (o_valid) begin
                if (keys_due.size() == 0) begin
                    $error("squared_distance: expected none, got %0d", o_squared_distance);
                    fail_count++;
                end else begin
                    want = keys_due.pop_front();
                    if (o_squared_distance !== want.sq_dist) begin
                        $error("squared_distance: expected %0d, got %0d",
                               want.sq_dist, o_squared_distance);
                        fail_count++;
                    end
                    if (o_run_last !== want.last) begin
                        $error("run_last: expected %0b, got %0b", want.last, o_run_last);
                        fail_count++;
                    end
                    if (o_overflowed !== want.ovf) begin
                        $error("overflowed: expected %0b, got %0b", want.ovf, o_overflowed);
                        fail_count++;
                    end
                end
            end

            if (start && !busy) begin
                key = squared_key(i_x_coord, i_y_coord);
                // store in order when there is room, else mark the set as lossy
                if (set_keys.size() < CAP) begin
                    pos = 0;
                    while (pos < set_keys.size() && set_keys[pos] <= key) pos++;
                    set_keys.insert(pos, key);
                end else begin
                    set_dropped = 1'b1;
                end
                // on the final point release the whole set as one ascending run
                if (i_final_point) begin
                    foreach (set_keys[i]) begin
                        want.sq_dist = set_keys[i];
                        want.last    = (i == set_keys.size() - 1);
                        want.ovf     = set_dropped;
                        keys_due.insert(keys_due.size(), want);
                    end
                    set_keys.delete();
                    set_dropped = 1'b0;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int queued;
        int n;

        // Directed set: coordinate extremes, the largest key, zero, and ties.
        push_point(0, 0, 1'b0);
        push_point(-32768, -32768, 1'b0);
        push_point(32767, 32767, 1'b0);
        push_point(-32768, 0, 1'b0);
        push_point(0, 32767, 1'b0);
        push_point(1, -1, 1'b0);
        push_point(-1, 1, 1'b0);
        push_point(3, 4, 1'b0);
        push_point(-4, 3, 1'b0);
        push_point(5, 0, 1'b0);
        push_point(-32768, 32767, 1'b0);
        push_point(0, 0, 1'b1);
        // a set made of the final point alone
        push_point(7, -7, 1'b1);
        // nothing but duplicates
        push_point(2, 2, 1'b0);
        push_point(-2, -2, 1'b1);

        // Random sets: exactly full, full with the final point dropped, well past full.
        push_random_set(CAP);
        push_random_set(CAP + 1);
        push_random_set(CAP + 3);
        queued = 3 * CAP + 4;
        // then mostly short sets with an occasional one near capacity
        while (queued < RAND_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(CAP - 4, CAP + 6);
            else
                n = $urandom_range(1, 12);
            push_random_set(n);
            queued += n;
        end

        // hold reset, then release it
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait until every request is taken and every expected key has come out
        while (point_queue.size() > 0 || start || keys_due.size() > 0)
            @(negedge i_clk);
        // give any stray strobe time to show up
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
